// File: rtl/core/lfbd_pkg.sv
package lfbd_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;

   localparam logic [BYTE_W-1:0] HDR_A = 8'hFE;
   localparam logic [BYTE_W-1:0] HDR_B = 8'hEE;
   localparam logic [BYTE_W-1:0] TRL_A = 8'hFC;
   localparam logic [BYTE_W-1:0] TRL_B = 8'hFF;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_HDR_B = 4'd1,
      PH_LEN   = 4'd2,
      PH_DATA  = 4'd4,
      PH_CK_HI = 4'd5,
      PH_CK_LO = 4'd6,
      PH_TRL_A = 4'd7,
      PH_TRL_B = 4'd8,
      PH_READ  = 4'd9,
      PH_LOAD  = 4'd10
   } phase_type;

   typedef struct packed {
      logic wr_len;
      logic wr_data;
      logic clr_k;
      logic rd_en;
      logic load_out;
      logic inc_k;
   } cmd_type;

   typedef struct packed {
      logic is_hdr_a;
      logic is_hdr_b;
      logic is_trl_a;
      logic is_trl_b;
      logic len_zero;
      logic len_over;
      logic data_done;
      logic last;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/lfbd_req_if.sv
interface lfbd_req_if;
   import lfbd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/lfbd_rsp_if.sv
interface lfbd_rsp_if;
   import lfbd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic [POS_W-1:0]  byte_position;
   logic              last_byte;

   modport source (output valid, output frame_byte, output byte_position,
                   output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input byte_position,
                   input last_byte, output ready);
endinterface

// File: rtl/core/length_framed_byte_deframer.sv
// Length-framed byte deframer. Takes one received byte per transfer and
// recognizes frames 0xFE 0xEE LEN payload[LEN] CK CK 0xFC 0xFF; the two
// checksum bytes are not checked, a mismatch in header or trailer drops back
// to hunting, and a length above MAX_PAYLOAD drops the frame silently. While
// framing, req_ready is high and one byte is taken every cycle in which
// req_valid is high. After the closing 0xFF, req_ready goes low while LEN+1
// bytes (the length byte at position 0, then the payload, last one flagged)
// are read back from the frame store; each byte passes through the store's
// registered read port and then the output register, and readout waits
// whenever rsp stalls the output register. The final result may still be
// waiting in the output register while the next frame is received.
module length_framed_byte_deframer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   lfbd_req_if.sink   req_chan,
   lfbd_rsp_if.source rsp_chan
);
   import lfbd_pkg::*;

   cmd_type    cmd;
   status_type status;

   lfbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfbd_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .rx_byte  (req_chan.rx_byte),
      .cmd      (cmd),
      .status   (status),
      .rsp_chan (rsp_chan)
   );
endmodule

// File: rtl/core/lfbd_ram.sv
module lfbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/lfbd_datapath.sv
module lfbd_datapath #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [lfbd_pkg::BYTE_W-1:0] rx_byte,
   input  lfbd_pkg::cmd_type     cmd,
   output lfbd_pkg::status_type  status,
   lfbd_rsp_if.source            rsp_chan
);
   import lfbd_pkg::*;

   localparam int DEPTH = MAX_PAYLOAD + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [BYTE_W-1:0] MAX_B = BYTE_W'(MAX_PAYLOAD);

   logic [POS_W-1:0]  payload_count_ff, payload_count_in;
   logic [BYTE_W-1:0] frame_length_ff, frame_length_in;
   logic [POS_W-1:0]  k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [POS_W-1:0]  count_inc;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   assign count_inc = payload_count_ff + POS_W'(1);

   assign ram_wr_en   = cmd.wr_len | cmd.wr_data;
   assign ram_wr_addr = cmd.wr_len ? AW'(0) : count_inc[AW-1:0];

   lfbd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      status.is_hdr_a  = (rx_byte == HDR_A);
      status.is_hdr_b  = (rx_byte == HDR_B);
      status.is_trl_a  = (rx_byte == TRL_A);
      status.is_trl_b  = (rx_byte == TRL_B);
      status.len_zero  = (rx_byte == '0);
      status.len_over  = (rx_byte > MAX_B);
      status.data_done = ({{(BYTE_W-POS_W){1'b0}}, count_inc} >= frame_length_ff);
      status.last      = ({{(BYTE_W-POS_W){1'b0}}, k_ff} == frame_length_ff);
      status.out_free  = !rsp_valid_ff || rsp_chan.ready;
   end

   always_comb begin
      payload_count_in = payload_count_ff;
      frame_length_in  = frame_length_ff;
      k_in             = k_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in      = rsp_byte_ff;
      rsp_pos_in       = rsp_pos_ff;
      rsp_last_in      = rsp_last_ff;
      if (cmd.wr_len) begin
         payload_count_in = '0;
         frame_length_in  = rx_byte;
      end
      if (cmd.wr_data) begin
         payload_count_in = count_inc;
      end
      if (cmd.clr_k) begin
         k_in = '0;
      end
      if (cmd.inc_k) begin
         k_in = k_ff + POS_W'(1);
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = ram_rd_data;
         rsp_pos_in   = k_ff;
         rsp_last_in  = status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_count_ff <= '0;
         frame_length_ff  <= '0;
         k_ff             <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         payload_count_ff <= payload_count_in;
         frame_length_ff  <= frame_length_in;
         k_ff             <= k_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.frame_byte    = rsp_byte_ff;
   assign rsp_chan.byte_position = rsp_pos_ff;
   assign rsp_chan.last_byte     = rsp_last_ff;
endmodule

// File: rtl/core/lfbd_ctrl.sv
module lfbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lfbd_pkg::status_type status,
   output lfbd_pkg::cmd_type    cmd
);
   import lfbd_pkg::*;

   phase_type phase_ff, phase_in;
   logic      acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      cmd       = '0;
      req_ready = 1'b1;
      acc       = req_valid;
      case (phase_ff)
         PH_HUNT: begin
            if (acc) begin
               phase_in = status.is_hdr_a ? PH_HDR_B : PH_HUNT;
            end
         end
         PH_HDR_B: begin
            if (acc) begin
               phase_in = status.is_hdr_b ? PH_LEN : PH_HUNT;
            end
         end
         PH_LEN: begin
            if (acc) begin
               cmd.wr_len = 1'b1;
               if (status.len_zero) begin
                  phase_in = PH_CK_HI;
               end else if (status.len_over) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (acc) begin
               cmd.wr_data = 1'b1;
               if (status.data_done) begin
                  phase_in = PH_CK_HI;
               end
            end
         end
         PH_CK_HI: begin
            if (acc) begin
               phase_in = PH_CK_LO;
            end
         end
         PH_CK_LO: begin
            if (acc) begin
               phase_in = PH_TRL_A;
            end
         end
         PH_TRL_A: begin
            if (acc) begin
               phase_in = status.is_trl_a ? PH_TRL_B : PH_HUNT;
            end
         end
         PH_TRL_B: begin
            if (acc) begin
               cmd.clr_k = 1'b1;
               phase_in  = status.is_trl_b ? PH_READ : PH_HUNT;
            end
         end
         PH_READ: begin
            req_ready  = 1'b0;
            cmd.rd_en  = 1'b1;
            phase_in   = PH_LOAD;
         end
         PH_LOAD: begin
            req_ready = 1'b0;
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last) begin
                  phase_in = PH_HUNT;
               end else begin
                  cmd.inc_k = 1'b1;
                  phase_in  = PH_READ;
               end
            end
         end
         default: begin
            if (acc) begin
               phase_in = status.is_hdr_a ? PH_HDR_B : PH_HUNT;
            end
         end
      endcase
   end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lfbd_pkg::*;

   localparam int MAX_PAYLOAD  = 32;
   localparam int STORE_DEPTH  = MAX_PAYLOAD + 1;
   localparam int DRAIN_CYCLES = 100;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_HDR,
      FRAME_BAD_TRL_A,
      FRAME_BAD_TRL_B,
      FRAME_CUT
   } frame_flaw_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              last;
   } frame_out_type;

   logic clock;
   logic reset;

   lfbd_req_if req_chan ();
   lfbd_rsp_if rsp_chan ();

   length_framed_byte_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // deframer shadow state
   phase_type         rx_phase;
   logic [5:0]        rx_count;
   logic [BYTE_W-1:0] rx_len;
   logic [BYTE_W-1:0] rx_store [STORE_DEPTH];

   frame_out_type pending_frame_bytes[$];
   frame_out_type want_byte;
   int            mismatches;
   bit            sender_gaps;
   bit            receiver_stalls;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      int            lim;
      frame_out_type item;
      case (rx_phase)
         PH_HDR_B: rx_phase = (b == HDR_B) ? PH_LEN : PH_HUNT;
         PH_LEN: begin
            rx_count    = '0;
            rx_len      = b;
            rx_store[0] = b;
            if (b == 0)
               rx_phase = PH_CK_HI;
            else if (int'(b) > MAX_PAYLOAD)
               rx_phase = PH_HUNT;
            else
               rx_phase = PH_DATA;
         end
         PH_DATA: begin
            if (int'(rx_count) + 1 < STORE_DEPTH)
               rx_store[int'(rx_count) + 1] = b;
            rx_count = rx_count + 6'd1;
            if (int'(rx_count) >= int'(rx_len))
               rx_phase = PH_CK_HI;
         end
         PH_CK_HI: rx_phase = PH_CK_LO;
         PH_CK_LO: rx_phase = PH_TRL_A;
         PH_TRL_A: rx_phase = (b == TRL_A) ? PH_TRL_B : PH_HUNT;
         PH_TRL_B: begin
            if (b == TRL_B) begin
               lim = (int'(rx_len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(rx_len);
               for (int k = 0; k <= lim; k++) begin
                  item.data = rx_store[k];
                  item.pos  = POS_W'(k);
                  item.last = (k == lim);
                  pending_frame_bytes.push_back(item);
               end
            end
            rx_phase = PH_HUNT;
         end
         default: rx_phase = (b == HDR_A) ? PH_HDR_B : PH_HUNT;
      endcase
   endfunction

   // predict on accepted input first, then check accepted output
   always @(posedge clock) begin
      if (reset) begin
         rx_phase = PH_HUNT;
         rx_count = '0;
         rx_len   = '0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            deframe_byte(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_frame_bytes.size() == 0) begin
               $display("%0t: unexpected transfer: expected none, got byte %h pos %0d last %b",
                        $time, rsp_chan.frame_byte, rsp_chan.byte_position,
                        rsp_chan.last_byte);
               mismatches++;
            end else begin
               want_byte = pending_frame_bytes.pop_front();
               if (rsp_chan.frame_byte !== want_byte.data) begin
                  $display("%0t: frame_byte expected %h got %h",
                           $time, want_byte.data, rsp_chan.frame_byte);
                  mismatches++;
               end
               if (rsp_chan.byte_position !== want_byte.pos) begin
                  $display("%0t: byte_position expected %0d got %0d",
                           $time, want_byte.pos, rsp_chan.byte_position);
                  mismatches++;
               end
               if (rsp_chan.last_byte !== want_byte.last) begin
                  $display("%0t: last_byte expected %b got %b",
                           $time, want_byte.last, rsp_chan.last_byte);
                  mismatches++;
               end
            end
         end
      end
   end

   // receiver backpressure
   initial begin
      forever begin
         if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.rx_byte = b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic wait_results_done();
      req_chan.valid = 1'b0;
      while (pending_frame_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: begin
            case ($urandom_range(0, 3))
               0: return HDR_A;
               1: return HDR_B;
               2: return TRL_A;
               default: return TRL_B;
            endcase
         end
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] v;
      v = BYTE_W'($urandom_range(0, 255));
      return (v == b) ? ~b : v;
   endfunction

   task automatic send_frame(input int len, input frame_flaw_type flaw);
      int n;
      send_byte(HDR_A);
      if (flaw == FRAME_BAD_HDR) begin
         send_byte(other_than(HDR_B));
         return;
      end
      send_byte(HDR_B);
      send_byte(BYTE_W'(len));
      if (len > MAX_PAYLOAD)
         return;
      n = (flaw == FRAME_CUT) ? $urandom_range(0, len) : len;
      repeat (n) send_byte(pick_byte());
      if (flaw == FRAME_CUT)
         return;
      send_byte(pick_byte());
      send_byte(pick_byte());
      if (flaw == FRAME_BAD_TRL_A) begin
         send_byte(other_than(TRL_A));
         return;
      end
      send_byte(TRL_A);
      send_byte((flaw == FRAME_BAD_TRL_B) ? other_than(TRL_B) : TRL_B);
   endtask

   task automatic test_header_mismatch();
      // non-EE after FE, then FE FE EE: the second FE is not a new start
      send_byte(HDR_A);
      send_byte(8'h12);
      send_byte(HDR_A);
      send_byte(HDR_A);
      send_byte(HDR_B);
   endtask

   task automatic test_zero_length();
      // checksum slots hold header/trailer values, must be skipped
      send_byte(HDR_A);
      send_byte(HDR_B);
      send_byte(8'h00);
      send_byte(HDR_A);
      send_byte(TRL_A);
      send_byte(TRL_A);
      send_byte(TRL_B);
   endtask

   task automatic test_over_length();
      send_frame(MAX_PAYLOAD + 1, FRAME_GOOD);
      send_frame(255, FRAME_GOOD);
   endtask

   task automatic test_trailer_mismatch();
      send_byte(HDR_A);
      send_byte(HDR_B);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFB);
      send_byte(TRL_B);
      send_frame(1, FRAME_BAD_TRL_B);
   endtask

   task automatic test_max_frame();
      send_frame(MAX_PAYLOAD, FRAME_GOOD);
      send_frame(1, FRAME_GOOD);
      wait_results_done();
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int             sent;
      int             len;
      int             r;
      frame_flaw_type flaw;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) send_byte(pick_byte());
         r = $urandom_range(0, 99);
         if (r < 45)
            len = $urandom_range(0, 3);
         else if (r < 70)
            len = $urandom_range(4, 10);
         else if (r < 80)
            len = $urandom_range(11, MAX_PAYLOAD - 1);
         else if (r < 86)
            len = MAX_PAYLOAD;
         else if (r < 94)
            len = $urandom_range(MAX_PAYLOAD + 1, 255);
         else
            len = 0;
         r = $urandom_range(0, 99);
         if (r < 75)
            flaw = FRAME_GOOD;
         else if (r < 81)
            flaw = FRAME_BAD_HDR;
         else if (r < 87)
            flaw = FRAME_BAD_TRL_A;
         else if (r < 93)
            flaw = FRAME_BAD_TRL_B;
         else
            flaw = FRAME_CUT;
         send_frame(len, flaw);
         sent += (len > MAX_PAYLOAD) ? 3 : len + 7;
      end
   endtask

   initial begin
      mismatches       = 0;
      sender_gaps      = 1'b1;
      receiver_stalls  = 1'b1;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_header_mismatch();
      test_zero_length();
      test_over_length();
      test_trailer_mismatch();
      test_max_frame();
      test_random_traffic(300);
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      test_random_traffic(60);
      wait_results_done();

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/lfbd_pkg.sv
rtl/core/lfbd_req_if.sv
rtl/core/lfbd_rsp_if.sv
rtl/core/lfbd_ram.sv
rtl/core/lfbd_datapath.sv
rtl/core/lfbd_ctrl.sv
rtl/core/length_framed_byte_deframer.sv
test/tb_top.sv
